// ===== rtl/clt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clt_pkg
// Shared types, codes and lookup functions for the C-like source tokenizer.
// ----------------------------------------------------------------------------
package clt_pkg;

    localparam int LENGTH_BITS_DEF = 16;
    localparam int QDEPTH          = 4;
    localparam int KW_COUNT        = 17;
    localparam int KW_SLOTS        = 9;

    // scan modes
    localparam logic [3:0] MD_IDLE     = 4'd0;
    localparam logic [3:0] MD_IDENT    = 4'd1;
    localparam logic [3:0] MD_ZERO     = 4'd2;
    localparam logic [3:0] MD_INT      = 4'd3;
    localparam logic [3:0] MD_OPER     = 4'd4;
    localparam logic [3:0] MD_CH_OPEN  = 4'd5;
    localparam logic [3:0] MD_CH_ESC   = 4'd6;
    localparam logic [3:0] MD_CH_CLOSE = 4'd7;
    localparam logic [3:0] MD_STR      = 4'd8;
    localparam logic [3:0] MD_DISCARD  = 4'd9;

    // result types
    localparam logic [1:0] RT_TOKEN = 2'd0;
    localparam logic [1:0] RT_TEXT  = 2'd1;
    localparam logic [1:0] RT_ERROR = 2'd2;

    // token kinds
    localparam logic [6:0] K_NONE  = 7'd0;
    localparam logic [6:0] K_EOF   = 7'd0;
    localparam logic [6:0] K_INT   = 7'd1;
    localparam logic [6:0] K_IDENT = 7'd2;
    localparam logic [6:0] K_STR   = 7'd3;
    localparam logic [6:0] K_KW0   = 7'd4;
    localparam logic [6:0] K_SHL   = 7'd50;
    localparam logic [6:0] K_SHR   = 7'd54;

    // error codes
    localparam logic [2:0] E_BAD_CHAR   = 3'd0;
    localparam logic [2:0] E_BAD_DIGIT  = 3'd1;
    localparam logic [2:0] E_OVERFLOW   = 3'd2;
    localparam logic [2:0] E_BAD_ESC    = 3'd3;
    localparam logic [2:0] E_EMPTY_CHAR = 3'd4;
    localparam logic [2:0] E_CHAR_OPEN  = 3'd5;
    localparam logic [2:0] E_STR_OPEN   = 3'd6;

    // radix selects
    localparam logic [1:0] RX_DEC = 2'd0;
    localparam logic [1:0] RX_OCT = 2'd1;
    localparam logic [1:0] RX_HEX = 2'd2;
    localparam logic [1:0] RX_BIN = 2'd3;

    localparam logic [71:0] KW_TEXT [KW_COUNT] = '{
        72'("var"), 72'("const"), 72'("if"), 72'("else"), 72'("while"),
        72'("for"), 72'("switch"), 72'("otherwise"), 72'("return"), 72'("fn"),
        72'("struct"), 72'("union"), 72'("enum"), 72'("type"), 72'("continue"),
        72'("break"), 72'("cast")
    };
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd3, 4'd5, 4'd2, 4'd4, 4'd5, 4'd3, 4'd6, 4'd9, 4'd6, 4'd2,
        4'd6, 4'd5, 4'd4, 4'd4, 4'd8, 4'd5, 4'd4
    };

    typedef struct packed {
        logic [1:0]  rtype;
        logic [6:0]  kind;
        logic [63:0] value;
        logic [7:0]  tbyte;
        logic [15:0] tlen;
        logic [2:0]  err;
    } res_t;

    typedef struct packed {
        logic two;
        res_t r0;
        res_t r1;
    } pair_t;

    function automatic res_t mk_res(input logic [1:0] rtype, input logic [6:0] kind,
                                    input logic [63:0] value, input logic [7:0] tbyte,
                                    input logic [15:0] tlen, input logic [2:0] err);
        res_t r;
        r.rtype = rtype;
        r.kind  = kind;
        r.value = value;
        r.tbyte = tbyte;
        r.tlen  = tlen;
        r.err   = err;
        return r;
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
    endfunction

    function automatic logic is_num(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    // {valid, value}
    function automatic logic [4:0] digit_of(input logic [7:0] b);
        logic [7:0] t;
        t = 8'd0;
        if (b >= "0" && b <= "9") t = b - 8'("0");
        else if (b >= "a" && b <= "f") t = b - 8'("a") + 8'd10;
        else if (b >= "A" && b <= "F") t = b - 8'("A") + 8'd10;
        else return 5'd0;
        return {1'b1, t[3:0]};
    endfunction

    // {valid, value}
    function automatic logic [8:0] esc_val(input logic [7:0] b, input logic [7:0] quote);
        case (b)
            "0":     return {1'b1, 8'd0};
            "n":     return {1'b1, 8'd10};
            "t":     return {1'b1, 8'd9};
            "r":     return {1'b1, 8'd13};
            "b":     return {1'b1, 8'd8};
            "\\":    return {1'b1, 8'd92};
            default: return (b == quote) ? {1'b1, quote} : 9'd0;
        endcase
    endfunction

    function automatic logic [6:0] op_start(input logic [7:0] b);
        case (b)
            "-":     return 7'd21;
            "&":     return 7'd25;
            "|":     return 7'd28;
            "~":     return 7'd31;
            "^":     return 7'd33;
            "+":     return 7'd35;
            "*":     return 7'd38;
            "/":     return 7'd40;
            "%":     return 7'd42;
            "=":     return 7'd44;
            "!":     return 7'd46;
            "<":     return 7'd48;
            ">":     return 7'd52;
            default: return K_NONE;
        endcase
    endfunction

    function automatic logic [6:0] op_single(input logic [7:0] b);
        case (b)
            "?":     return 7'd56;
            ":":     return 7'd57;
            ";":     return 7'd58;
            ",":     return 7'd59;
            "{":     return 7'd60;
            "}":     return 7'd61;
            "[":     return 7'd62;
            "]":     return 7'd63;
            "(":     return 7'd64;
            ")":     return 7'd65;
            ".":     return 7'd66;
            default: return K_NONE;
        endcase
    endfunction

    function automatic logic [6:0] op_extend(input logic [6:0] p, input logic [7:0] b);
        case (p) inside
            7'd21: return b == ">" ? 7'd22 : b == "=" ? 7'd23 : b == "-" ? 7'd24 : K_NONE;
            7'd25: return b == "&" ? 7'd26 : b == "=" ? 7'd27 : K_NONE;
            7'd28: return b == "|" ? 7'd29 : b == "=" ? 7'd30 : K_NONE;
            7'd35: return b == "=" ? 7'd36 : b == "+" ? 7'd37 : K_NONE;
            7'd48: return b == "=" ? 7'd49 : b == "<" ? 7'd50 : K_NONE;
            7'd52: return b == "=" ? 7'd53 : b == ">" ? 7'd54 : K_NONE;
            7'd31, 7'd33, 7'd38, 7'd40, 7'd42, 7'd44, 7'd46, 7'd50, 7'd54:
                return b == "=" ? p + 7'd1 : K_NONE;
            default: return K_NONE;
        endcase
    endfunction

    // buffer byte i sits at bits [i*8 +: 8]; len is 0 when too long for a keyword
    function automatic logic [6:0] kw_kind(input logic [71:0] buf_bytes,
                                           input logic [3:0] len);
        logic [6:0] kind;
        logic       hit;
        kind = K_IDENT;
        for (int k = KW_COUNT - 1; k >= 0; k--) begin
            hit = (len == KW_LEN[k]);
            for (int i = 0; i < KW_SLOTS; i++) begin
                if (4'(i) < KW_LEN[k] &&
                    buf_bytes[i*8 +: 8] !=
                        KW_TEXT[k][(int'(KW_LEN[k]) - 1 - i)*8 +: 8])
                    hit = 1'b0;
            end
            if (hit) kind = K_KW0 + 7'(k);
        end
        return kind;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/clt_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clt_front
// Scanner: takes one source byte per transfer, updates the lexer state and
// hands the one or two results of that byte, if any, to the queue as a pair.
// ----------------------------------------------------------------------------
module clt_front #(
    parameter int LENGTH_BITS = clt_pkg::LENGTH_BITS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [7:0]    s_tdata,
    input  wire logic          q_room,
    output logic               q_push,
    output clt_pkg::pair_t     q_data
);
    import clt_pkg::*;

    logic [3:0]             mode_reg, mode_next;
    logic [6:0]             pend_reg, pend_next;
    logic [63:0]            acc_reg, acc_next;
    logic [1:0]             radix_reg, radix_next;
    logic [LENGTH_BITS-1:0] cnt_reg, cnt_next;
    logic                   esc_reg, esc_next;
    logic [7:0]             kw_buf_reg [KW_SLOTS];

    logic                   fire;
    logic [7:0]             b;
    logic                   a_v, s_v, do_start, fail_v;
    res_t                   a_r, s_r;
    logic [2:0]             fail_code;
    logic                   kw_we;
    logic [3:0]             kw_idx;
    logic [LENGTH_BITS-1:0] cnt_inc;
    logic [31:0]            cnt_wide;
    logic [15:0]            cnt_len;
    logic [71:0]            kw_flat;
    logic [3:0]             kw_len;
    logic [4:0]             dg;
    logic [1:0]             rsel;
    logic [4:0]             rad_val;
    logic [67:0]            prod;
    logic [67:0]            mac;
    logic [8:0]             ev;
    logic [6:0]             ext, k1, k2;

    assign s_tready = q_room;
    assign fire     = s_tvalid && q_room;
    assign b        = s_tdata;

    // saturating length and its 16-bit view
    assign cnt_inc  = (cnt_reg == '1) ? cnt_reg : cnt_reg + LENGTH_BITS'(1);
    assign cnt_wide = 32'(cnt_reg);
    assign cnt_len  = (cnt_wide > 32'h0000FFFF) ? 16'hFFFF : cnt_wide[15:0];

    // flatten keyword buffer for the match
    always_comb
    begin
        for (int i = 0; i < KW_SLOTS; i++) kw_flat[i*8 +: 8] = kw_buf_reg[i];
        kw_len = (cnt_wide <= 32'(KW_SLOTS)) ? cnt_wide[3:0] : 4'd0;
    end

    // multiply-add for the number in progress
    always_comb
    begin
        rsel = (mode_reg == MD_ZERO) ? RX_OCT : radix_reg;
        dg   = digit_of(b);
        case (rsel)
            RX_DEC:  begin rad_val = 5'd10; prod = {1'b0, acc_reg, 3'b0} + {3'b0, acc_reg, 1'b0}; end
            RX_OCT:  begin rad_val = 5'd8;  prod = {1'b0, acc_reg, 3'b0}; end
            RX_HEX:  begin rad_val = 5'd16; prod = {acc_reg, 4'b0}; end
            default: begin rad_val = 5'd2;  prod = {3'b0, acc_reg, 1'b0}; end
        endcase
        mac = prod + {64'd0, dg[3:0]};
    end

    assign ev  = esc_val(b, (mode_reg == MD_STR) ? 8'h22 : 8'h27);
    assign ext = op_extend(pend_reg, b);
    assign k1  = op_start(b);
    assign k2  = op_single(b);

    // next-state logic
    always_comb
    begin
        mode_next  = mode_reg;
        pend_next  = pend_reg;
        acc_next   = acc_reg;
        radix_next = radix_reg;
        cnt_next   = cnt_reg;
        esc_next   = esc_reg;
        a_v        = 1'b0;
        a_r        = '0;
        s_v        = 1'b0;
        s_r        = '0;
        do_start   = 1'b0;
        fail_v     = 1'b0;
        fail_code  = E_BAD_CHAR;
        kw_we      = 1'b0;
        kw_idx     = cnt_reg[3:0];

        unique case (mode_reg)
            MD_IDENT:
            begin
                if (is_alpha(b) || is_num(b))
                begin
                    kw_we    = (cnt_wide < 32'(KW_SLOTS));
                    cnt_next = cnt_inc;
                    a_v      = 1'b1;
                    a_r      = mk_res(RT_TEXT, K_NONE, 64'd0, b, 16'd0, 3'd0);
                end
                else
                begin
                    a_v      = 1'b1;
                    a_r      = mk_res(RT_TOKEN, kw_kind(kw_flat, kw_len), 64'd0, 8'd0,
                                      cnt_len, 3'd0);
                    do_start = 1'b1;
                end
            end
            MD_ZERO, MD_INT:
            begin
                if (mode_reg == MD_ZERO && (b == "x" || b == "X"))
                begin
                    radix_next = RX_HEX;
                    mode_next  = MD_INT;
                end
                else if (mode_reg == MD_ZERO && (b == "b" || b == "B"))
                begin
                    radix_next = RX_BIN;
                    mode_next  = MD_INT;
                end
                else
                begin
                    radix_next = rsel;
                    mode_next  = MD_INT;
                    if (b == "_")
                    begin
                        // separator, keep going
                    end
                    else if (!dg[4])
                    begin
                        a_v      = 1'b1;
                        a_r      = mk_res(RT_TOKEN, K_INT, acc_reg, 8'd0, 16'd0, 3'd0);
                        do_start = 1'b1;
                    end
                    else if ({1'b0, dg[3:0]} >= rad_val)
                    begin
                        fail_v    = 1'b1;
                        fail_code = E_BAD_DIGIT;
                    end
                    else if (|mac[67:64])
                    begin
                        fail_v    = 1'b1;
                        fail_code = E_OVERFLOW;
                    end
                    else
                    begin
                        acc_next = mac[63:0];
                    end
                end
            end
            MD_OPER:
            begin
                if (ext == K_SHL || ext == K_SHR)
                begin
                    pend_next = ext;
                end
                else if (ext != K_NONE)
                begin
                    a_v       = 1'b1;
                    a_r       = mk_res(RT_TOKEN, ext, 64'd0, 8'd0, 16'd0, 3'd0);
                    pend_next = K_NONE;
                    mode_next = MD_IDLE;
                end
                else
                begin
                    a_v       = 1'b1;
                    a_r       = mk_res(RT_TOKEN, pend_reg, 64'd0, 8'd0, 16'd0, 3'd0);
                    pend_next = K_NONE;
                    do_start  = 1'b1;
                end
            end
            MD_CH_OPEN:
            begin
                if (b == 8'd0)
                begin
                    fail_v    = 1'b1;
                    fail_code = E_CHAR_OPEN;
                end
                else if (b == 8'h27)
                begin
                    fail_v    = 1'b1;
                    fail_code = E_EMPTY_CHAR;
                end
                else if (b == 8'h5C)
                begin
                    mode_next = MD_CH_ESC;
                end
                else
                begin
                    acc_next  = {56'd0, b};
                    mode_next = MD_CH_CLOSE;
                end
            end
            MD_CH_ESC:
            begin
                if (b == 8'd0)
                begin
                    fail_v    = 1'b1;
                    fail_code = E_CHAR_OPEN;
                end
                else if (!ev[8])
                begin
                    fail_v    = 1'b1;
                    fail_code = E_BAD_ESC;
                end
                else
                begin
                    acc_next  = {56'd0, ev[7:0]};
                    mode_next = MD_CH_CLOSE;
                end
            end
            MD_CH_CLOSE:
            begin
                if (b == 8'h27)
                begin
                    a_v       = 1'b1;
                    a_r       = mk_res(RT_TOKEN, K_INT, acc_reg, 8'd0, 16'd0, 3'd0);
                    mode_next = MD_IDLE;
                end
                else
                begin
                    fail_v    = 1'b1;
                    fail_code = E_CHAR_OPEN;
                end
            end
            MD_STR:
            begin
                if (b == 8'd0)
                begin
                    fail_v    = 1'b1;
                    fail_code = E_STR_OPEN;
                end
                else if (esc_reg)
                begin
                    esc_next = 1'b0;
                    if (!ev[8])
                    begin
                        fail_v    = 1'b1;
                        fail_code = E_BAD_ESC;
                    end
                    else
                    begin
                        cnt_next = cnt_inc;
                        a_v      = 1'b1;
                        a_r      = mk_res(RT_TEXT, K_NONE, 64'd0, ev[7:0], 16'd0, 3'd0);
                    end
                end
                else if (b == 8'h22)
                begin
                    a_v       = 1'b1;
                    a_r       = mk_res(RT_TOKEN, K_STR, 64'd0, 8'd0, cnt_len, 3'd0);
                    mode_next = MD_IDLE;
                end
                else if (b == 8'h5C)
                begin
                    esc_next = 1'b1;
                end
                else
                begin
                    cnt_next = cnt_inc;
                    a_v      = 1'b1;
                    a_r      = mk_res(RT_TEXT, K_NONE, 64'd0, b, 16'd0, 3'd0);
                end
            end
            MD_DISCARD:
            begin
                if (b == 8'd0) mode_next = MD_IDLE;
            end
            default:
            begin
                do_start = 1'b1;
            end
        endcase

        // start a new token with this byte
        if (do_start)
        begin
            mode_next = MD_IDLE;
            if (b == 8'd0)
            begin
                s_v = 1'b1;
                s_r = mk_res(RT_TOKEN, K_EOF, 64'd0, 8'd0, 16'd0, 3'd0);
            end
            else if (b == " " || (b >= 8'd9 && b <= 8'd13))
            begin
                // whitespace
            end
            else if (is_num(b))
            begin
                acc_next   = {60'd0, dg[3:0]};
                radix_next = RX_DEC;
                mode_next  = (b == "0") ? MD_ZERO : MD_INT;
            end
            else if (is_alpha(b))
            begin
                mode_next = MD_IDENT;
                kw_we     = 1'b1;
                kw_idx    = 4'd0;
                cnt_next  = LENGTH_BITS'(1);
                s_v       = 1'b1;
                s_r       = mk_res(RT_TEXT, K_NONE, 64'd0, b, 16'd0, 3'd0);
            end
            else if (b == 8'h27)
            begin
                acc_next  = 64'd0;
                mode_next = MD_CH_OPEN;
            end
            else if (b == 8'h22)
            begin
                cnt_next  = '0;
                esc_next  = 1'b0;
                mode_next = MD_STR;
            end
            else if (k1 != K_NONE)
            begin
                pend_next = k1;
                mode_next = MD_OPER;
            end
            else if (k2 != K_NONE)
            begin
                s_v = 1'b1;
                s_r = mk_res(RT_TOKEN, k2, 64'd0, 8'd0, 16'd0, 3'd0);
            end
            else
            begin
                fail_v    = 1'b1;
                fail_code = E_BAD_CHAR;
            end
        end

        // raise an error and drop bytes until end of text
        if (fail_v)
        begin
            pend_next = K_NONE;
            esc_next  = 1'b0;
            mode_next = (b == 8'd0) ? MD_IDLE : MD_DISCARD;
            if (do_start)
            begin
                s_v = 1'b1;
                s_r = mk_res(RT_ERROR, K_NONE, 64'd0, 8'd0, 16'd0, fail_code);
            end
            else
            begin
                a_v = 1'b1;
                a_r = mk_res(RT_ERROR, K_NONE, 64'd0, 8'd0, 16'd0, fail_code);
            end
        end
    end

    // pack the results of this byte
    always_comb
    begin
        q_push = fire && (a_v || s_v);
        q_data.two = a_v && s_v;
        q_data.r0  = a_v ? a_r : s_r;
        q_data.r1  = s_r;
    end

    // advance the scanner state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MD_IDLE;
            pend_reg  <= K_NONE;
            acc_reg   <= 64'd0;
            radix_reg <= RX_DEC;
            cnt_reg   <= '0;
            esc_reg   <= 1'b0;
        end
        else if (fire)
        begin
            mode_reg  <= mode_next;
            pend_reg  <= pend_next;
            acc_reg   <= acc_next;
            radix_reg <= radix_next;
            cnt_reg   <= cnt_next;
            esc_reg   <= esc_next;
        end
    end

    // hold identifier bytes for the keyword match
    always_ff @(posedge clk)
    begin
        if (fire && kw_we) kw_buf_reg[kw_idx] <= b;
    end

endmodule
`default_nettype wire

// ===== rtl/clt_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clt_queue
// Short queue of result pairs between the scanner and the output stage.
// ----------------------------------------------------------------------------
module clt_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire clt_pkg::pair_t push_data,
    output logic                room,
    input  wire logic           pop,
    output logic                avail,
    output clt_pkg::pair_t      pop_data
);
    import clt_pkg::*;

    localparam int QAW = $clog2(QDEPTH);

    pair_t            mem [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QAW:0]     count_reg;
    logic             do_push, do_pop;

    assign room     = (count_reg != (QAW+1)'(QDEPTH));
    assign avail    = (count_reg != '0);
    assign do_push  = push && room;
    assign do_pop   = pop && avail;
    assign pop_data = mem[rd_ptr_reg];

    // store pushed pair
    always_ff @(posedge clk)
    begin
        if (do_push) mem[wr_ptr_reg] <= push_data;
    end

    // advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push) wr_ptr_reg <= wr_ptr_reg + QAW'(1);
            if (do_pop)  rd_ptr_reg <= rd_ptr_reg + QAW'(1);
            if (do_push && !do_pop)      count_reg <= count_reg + (QAW+1)'(1);
            else if (do_pop && !do_push) count_reg <= count_reg - (QAW+1)'(1);
        end
    end

endmodule
`default_nettype wire

// ===== rtl/clt_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clt_back
// Output stage: unpacks result pairs into single transfers and marks the
// last result of each source byte.
// ----------------------------------------------------------------------------
module clt_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           avail,
    input  wire clt_pkg::pair_t pop_data,
    output logic                pop,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [103:0]        m_tdata,
    output logic [1:0]          m_tuser,
    output logic                m_tlast
);
    import clt_pkg::*;

    logic out_vld_reg, out_last_reg, hold_vld_reg;
    res_t out_res_reg, hold_res_reg;
    logic load;

    assign load = !out_vld_reg || m_tready;
    assign pop  = load && !hold_vld_reg && avail;

    // control of output and hold slots
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            out_last_reg <= 1'b0;
            hold_vld_reg <= 1'b0;
        end
        else if (load)
        begin
            if (hold_vld_reg)
            begin
                out_vld_reg  <= 1'b1;
                out_last_reg <= 1'b1;
                hold_vld_reg <= 1'b0;
            end
            else if (avail)
            begin
                out_vld_reg  <= 1'b1;
                out_last_reg <= !pop_data.two;
                hold_vld_reg <= pop_data.two;
            end
            else
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // result payloads
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (hold_vld_reg)
            begin
                out_res_reg <= hold_res_reg;
            end
            else if (avail)
            begin
                out_res_reg  <= pop_data.r0;
                hold_res_reg <= pop_data.r1;
            end
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_res_reg.rtype;
    assign m_tdata  = {6'd0, out_res_reg.err, out_res_reg.tlen, out_res_reg.tbyte,
                       out_res_reg.value, out_res_reg.kind};

`ifndef NO_ASSERTIONS
    a_hold_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        hold_vld_reg |-> out_vld_reg)
        else $error("second result held with no first result shown");
    a_hold_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        hold_vld_reg |-> !out_last_reg)
        else $error("result marked last while a second one waits");
    a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=> (m_tvalid && m_tlast))
        else $error("second result of a byte did not follow");
`endif

endmodule
`default_nettype wire

// ===== rtl/c_like_source_tokenizer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A result goes from the pair queue through the output register to m_tdata.
// Throughput: one byte per cycle while each byte gives at most one result and
// m_tready stays high; a byte with two results takes two output transfers.
// A four-entry pair queue lets the scanner run ahead of output stalls.
// Reset: asynchronous, clears scanner state, queue and output; the keyword
// buffer is not cleared and the block is ready right after reset.
// ----------------------------------------------------------------------------
// c_like_source_tokenizer
// Streaming lexer for a small C-like language, one source byte per transfer.
// ----------------------------------------------------------------------------
module c_like_source_tokenizer #(
    parameter int LENGTH_BITS = clt_pkg::LENGTH_BITS_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // char_byte
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [103:0]      m_tdata,   // token_kind, literal_value, text_byte,
                                         // text_length, error_code, zero pad
    output logic [1:0]        m_tuser,   // result_type
    output logic              m_tlast    // last_of_run
);
    import clt_pkg::*;

    logic  q_room, q_push, q_pop, q_avail;
    pair_t q_in, q_out;

    clt_front #(.LENGTH_BITS(LENGTH_BITS)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_room   (q_room),
        .q_push   (q_push),
        .q_data   (q_in)
    );

    clt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .room      (q_room),
        .pop       (q_pop),
        .avail     (q_avail),
        .pop_data  (q_out)
    );

    clt_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .avail    (q_avail),
        .pop_data (q_out),
        .pop      (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire
